### rtl/cpu_jump_call_return_unit_defines.svh
// ---------------------------------------------------------------------------
// cpu_jump_call_return_unit_defines.svh
// Assertion macros for the jump/call/return unit. They sample on i_clk and
// stay quiet while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CPU_JUMP_CALL_RETURN_UNIT_DEFINES_SVH
`define CPU_JUMP_CALL_RETURN_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CJCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define CJCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cjcr_pkg.sv
// ---------------------------------------------------------------------------
// cjcr_pkg
// Opcodes, instruction classes and stage payload types shared by the
// jump/call/return pipeline.
// ---------------------------------------------------------------------------
package cjcr_pkg;

    // instruction classes
    localparam logic [2:0] CLS_UNK  = 3'd0;
    localparam logic [2:0] CLS_JR   = 3'd1;
    localparam logic [2:0] CLS_JP   = 3'd2;
    localparam logic [2:0] CLS_CALL = 3'd3;
    localparam logic [2:0] CLS_RST  = 3'd4;
    localparam logic [2:0] CLS_RET  = 3'd5;
    localparam logic [2:0] CLS_JPHL = 3'd6;

    // opcodes
    localparam logic [7:0] OP_JR     = 8'h18;
    localparam logic [7:0] OP_JR_NZ  = 8'h20;
    localparam logic [7:0] OP_JR_Z   = 8'h28;
    localparam logic [7:0] OP_JR_NC  = 8'h30;
    localparam logic [7:0] OP_JR_C   = 8'h38;
    localparam logic [7:0] OP_JP     = 8'hC3;
    localparam logic [7:0] OP_JP_NZ  = 8'hC2;
    localparam logic [7:0] OP_JP_Z   = 8'hCA;
    localparam logic [7:0] OP_JP_NC  = 8'hD2;
    localparam logic [7:0] OP_JP_C   = 8'hDA;
    localparam logic [7:0] OP_CALL   = 8'hCD;
    localparam logic [7:0] OP_CALL_NZ = 8'hC4;
    localparam logic [7:0] OP_CALL_Z = 8'hCC;
    localparam logic [7:0] OP_CALL_NC = 8'hD4;
    localparam logic [7:0] OP_CALL_C = 8'hDC;
    localparam logic [7:0] OP_RST_00 = 8'hC7;
    localparam logic [7:0] OP_RST_08 = 8'hCF;
    localparam logic [7:0] OP_RST_10 = 8'hD7;
    localparam logic [7:0] OP_RST_18 = 8'hDF;
    localparam logic [7:0] OP_RST_20 = 8'hE7;
    localparam logic [7:0] OP_RST_28 = 8'hEF;
    localparam logic [7:0] OP_RST_30 = 8'hF7;
    localparam logic [7:0] OP_RST_38 = 8'hFF;
    localparam logic [7:0] OP_RET    = 8'hC9;
    localparam logic [7:0] OP_RETI   = 8'hD9;
    localparam logic [7:0] OP_RET_NZ = 8'hC0;
    localparam logic [7:0] OP_RET_Z  = 8'hC8;
    localparam logic [7:0] OP_RET_NC = 8'hD0;
    localparam logic [7:0] OP_RET_C  = 8'hD8;
    localparam logic [7:0] OP_JP_HL  = 8'hE9;

    // condition codes, opcode bits 4..3
    localparam logic [1:0] CC_NZ = 2'd0;
    localparam logic [1:0] CC_Z  = 2'd1;
    localparam logic [1:0] CC_NC = 2'd2;
    localparam logic [1:0] CC_C  = 2'd3;

    localparam int FLAG_Z_BIT = 7;
    localparam int FLAG_C_BIT = 4;

    // decoded control, built in the decode stage
    typedef struct packed {
        logic [2:0] cls;
        logic       taken;
        logic       ime;
        logic [2:0] rst_vec;
    } t_dec;

    // decode stage -> address stage
    typedef struct packed {
        t_dec        dec;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] hl;
        logic [15:0] imm;
        logic [15:0] stk;
    } t_s1_data;

    // address stage -> select stage
    typedef struct packed {
        t_dec        dec;
        logic [15:0] seq_pc;
        logic [15:0] adj_sp;
        logic [15:0] hl;
        logic [15:0] imm;
        logic [15:0] stk;
    } t_s2_data;

endpackage

### rtl/cpu_jump_call_return_unit.sv
// ---------------------------------------------------------------------------
// cpu_jump_call_return_unit
// Three-stage pipeline that resolves one jump, call, restart or return
// instruction per beat into next PC, next SP and stack-push information.
// ---------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  ------------------------------------------------
//  input    i_valid / o_ready  i_op i_pc i_sp i_flags i_hl i_imm_word
//                              i_stack_word
//  output   o_valid / i_ready  o_next_pc o_next_sp o_branch_taken o_push_valid
//                              o_push_word o_ime_set o_unknown_op
//
//  One beat enters per cycle while o_ready is high. A beat passes through the
//  decode, address and select register stages in that order, and its result is
//  held on the outputs until i_ready takes it.
//  Reset (synchronous, active low) empties all stages; there is no other state.
//  A stall on the output backs up stage by stage: a stage holds its beat
//  while the one after it is full and not moving, so bubbles are squeezed out
//  and no beat is lost or repeated.
//
`include "cpu_jump_call_return_unit_defines.svh"

module cpu_jump_call_return_unit
    import cjcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_op,
    input  logic [15:0] i_pc,
    input  logic [15:0] i_sp,
    input  logic [7:0]  i_flags,
    input  logic [15:0] i_hl,
    input  logic [15:0] i_imm_word,
    input  logic [15:0] i_stack_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic [15:0] o_next_sp,
    output logic        o_branch_taken,
    output logic        o_push_valid,
    output logic [15:0] o_push_word,
    output logic        o_ime_set,
    output logic        o_unknown_op
);

    logic     s1_valid;
    logic     s1_ready;
    t_s1_data s1_data;
    logic     s2_valid;
    logic     s2_ready;
    t_s2_data s2_data;

    // decode: classify opcode, evaluate NZ/Z/NC/C condition
    cjcr_decode_stage u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_pc         (i_pc),
        .i_sp         (i_sp),
        .i_flags      (i_flags),
        .i_hl         (i_hl),
        .i_imm_word   (i_imm_word),
        .i_stack_word (i_stack_word),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_data       (s1_data)
    );

    // address: fall-through PC past operand bytes, SP push/pop adjust
    cjcr_addr_stage u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // select: relative target add, final PC mux, output register
    cjcr_select_stage u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s2_valid),
        .o_ready        (s2_ready),
        .i_data         (s2_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_next_pc      (o_next_pc),
        .o_next_sp      (o_next_sp),
        .o_branch_taken (o_branch_taken),
        .o_push_valid   (o_push_valid),
        .o_push_word    (o_push_word),
        .o_ime_set      (o_ime_set),
        .o_unknown_op   (o_unknown_op)
    );

    // unknown opcodes leave every side effect off
    `CJCR_ASSERT_IMP(a_unknown_quiet, o_valid && o_unknown_op, !o_branch_taken && !o_push_valid && !o_ime_set && (o_push_word == 16'd0), "unknown opcode with side effects")
    // a push only happens on a taken call or restart
    `CJCR_ASSERT_IMP(a_push_taken, o_valid && o_push_valid, o_branch_taken && !o_unknown_op, "push without taken branch")
    // RETI always returns
    `CJCR_ASSERT_IMP(a_reti_taken, o_valid && o_ime_set, o_branch_taken && !o_push_valid, "RETI not taken as a return")
    // a beat handed from decode reaches the address stage
    `CJCR_ASSERT_NXT(a_s2_fill, s1_valid && s1_ready, s2_valid, "beat lost between decode and address")

endmodule

### rtl/cjcr_decode_stage.sv
// ---------------------------------------------------------------------------
// cjcr_decode_stage
// Stage 1: classify the opcode, evaluate its condition and register the beat.
// ---------------------------------------------------------------------------
module cjcr_decode_stage
    import cjcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_op,
    input  logic [15:0] i_pc,
    input  logic [15:0] i_sp,
    input  logic [7:0]  i_flags,
    input  logic [15:0] i_hl,
    input  logic [15:0] i_imm_word,
    input  logic [15:0] i_stack_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_s1_data    o_data
);

    logic     r_valid;
    t_s1_data r_data;
    t_s1_data n_data;
    logic     cond_ok;
    logic     flag_z;
    logic     flag_c;

    assign flag_z = i_flags[FLAG_Z_BIT];
    assign flag_c = i_flags[FLAG_C_BIT];

    always_comb begin
        unique case (i_op[4:3])
            CC_NZ:   cond_ok = !flag_z;
            CC_Z:    cond_ok = flag_z;
            CC_NC:   cond_ok = !flag_c;
            CC_C:    cond_ok = flag_c;
            default: cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_data.pc          = i_pc;
        n_data.sp          = i_sp;
        n_data.hl          = i_hl;
        n_data.imm         = i_imm_word;
        n_data.stk         = i_stack_word;
        n_data.dec.rst_vec = i_op[5:3];
        n_data.dec.ime     = (i_op == OP_RETI);
        unique case (i_op)
            OP_JR: begin
                n_data.dec.cls   = CLS_JR;
                n_data.dec.taken = 1'b1;
            end
            OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
                n_data.dec.cls   = CLS_JR;
                n_data.dec.taken = cond_ok;
            end
            OP_JP: begin
                n_data.dec.cls   = CLS_JP;
                n_data.dec.taken = 1'b1;
            end
            OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
                n_data.dec.cls   = CLS_JP;
                n_data.dec.taken = cond_ok;
            end
            OP_CALL: begin
                n_data.dec.cls   = CLS_CALL;
                n_data.dec.taken = 1'b1;
            end
            OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C: begin
                n_data.dec.cls   = CLS_CALL;
                n_data.dec.taken = cond_ok;
            end
            OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
            OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: begin
                n_data.dec.cls   = CLS_RST;
                n_data.dec.taken = 1'b1;
            end
            OP_RET, OP_RETI: begin
                n_data.dec.cls   = CLS_RET;
                n_data.dec.taken = 1'b1;
            end
            OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C: begin
                n_data.dec.cls   = CLS_RET;
                n_data.dec.taken = cond_ok;
            end
            OP_JP_HL: begin
                n_data.dec.cls   = CLS_JPHL;
                n_data.dec.taken = 1'b1;
            end
            default: begin
                n_data.dec.cls   = CLS_UNK;
                n_data.dec.taken = 1'b0;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/cjcr_addr_stage.sv
// ---------------------------------------------------------------------------
// cjcr_addr_stage
// Stage 2: form the fall-through PC and the adjusted stack pointer.
// ---------------------------------------------------------------------------
module cjcr_addr_stage
    import cjcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_s1_data i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s2_data o_data
);

    logic        r_valid;
    t_s2_data    r_data;
    t_s2_data    n_data;
    logic [15:0] pc_inc;
    logic [15:0] sp_delta;

    always_comb begin
        unique case (i_data.dec.cls)
            CLS_JR:           pc_inc = 16'd1;
            CLS_JP, CLS_CALL: pc_inc = 16'd2;
            default:          pc_inc = 16'd0;
        endcase
        // push moves SP down by two, pop moves it up by two
        sp_delta = 16'd0;
        if (i_data.dec.taken) begin
            unique case (i_data.dec.cls)
                CLS_CALL, CLS_RST: sp_delta = 16'hFFFE;
                CLS_RET:           sp_delta = 16'd2;
                default:           sp_delta = 16'd0;
            endcase
        end
    end

    always_comb begin
        n_data.dec    = i_data.dec;
        n_data.seq_pc = i_data.pc + pc_inc;
        n_data.adj_sp = i_data.sp + sp_delta;
        n_data.hl     = i_data.hl;
        n_data.imm    = i_data.imm;
        n_data.stk    = i_data.stk;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/cjcr_select_stage.sv
// ---------------------------------------------------------------------------
// cjcr_select_stage
// Stage 3: add the relative offset, pick the target and hold the result beat.
// ---------------------------------------------------------------------------
module cjcr_select_stage
    import cjcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_s2_data    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_next_pc,
    output logic [15:0] o_next_sp,
    output logic        o_branch_taken,
    output logic        o_push_valid,
    output logic [15:0] o_push_word,
    output logic        o_ime_set,
    output logic        o_unknown_op
);

    logic        r_valid;
    logic [15:0] r_next_pc;
    logic [15:0] r_next_sp;
    logic        r_branch_taken;
    logic        r_push_valid;
    logic [15:0] r_push_word;
    logic        r_ime_set;
    logic        r_unknown_op;
    logic [15:0] n_next_pc;
    logic        n_push_valid;
    logic [15:0] jr_target;

    assign jr_target = i_data.seq_pc + {{8{i_data.imm[7]}}, i_data.imm[7:0]};

    always_comb begin
        n_next_pc = i_data.seq_pc;
        if (i_data.dec.taken) begin
            unique case (i_data.dec.cls)
                CLS_JR:           n_next_pc = jr_target;
                CLS_JP, CLS_CALL: n_next_pc = i_data.imm;
                CLS_RST:          n_next_pc = {10'd0, i_data.dec.rst_vec, 3'd0};
                CLS_RET:          n_next_pc = i_data.stk;
                CLS_JPHL:         n_next_pc = i_data.hl;
                default:          n_next_pc = i_data.seq_pc;
            endcase
        end
    end

    assign n_push_valid = i_data.dec.taken &&
                          ((i_data.dec.cls == CLS_CALL) || (i_data.dec.cls == CLS_RST));

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_next_pc      <= n_next_pc;
            r_next_sp      <= i_data.adj_sp;
            r_branch_taken <= i_data.dec.taken;
            r_push_valid   <= n_push_valid;
            r_push_word    <= n_push_valid ? i_data.seq_pc : 16'd0;
            r_ime_set      <= i_data.dec.ime;
            r_unknown_op   <= (i_data.dec.cls == CLS_UNK);
        end
    end

    assign o_valid        = r_valid;
    assign o_next_pc      = r_next_pc;
    assign o_next_sp      = r_next_sp;
    assign o_branch_taken = r_branch_taken;
    assign o_push_valid   = r_push_valid;
    assign o_push_word    = r_push_word;
    assign o_ime_set      = r_ime_set;
    assign o_unknown_op   = r_unknown_op;

endmodule
